@@ rtl/core/record_ring_space_manager_macros.svh @@
// Assertion macros for the record ring space manager.
// Included by the top level; needs i_clk and i_rst_n in the including scope.
`ifndef RECORD_RING_SPACE_MANAGER_MACROS_SVH
`define RECORD_RING_SPACE_MANAGER_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define RRSM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("rrsm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RRSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("rrsm assertion failed");

`else

`define RRSM_ASSERT_SAME(label, ante, cons)
`define RRSM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/core/rrsm_pkg.sv @@
// Shared types and constants of the record ring space manager.
// Used by the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps

package rrsm_pkg;

    localparam int MSG_LEN_W = 13;
    localparam int OFS_W     = 12;
    localparam int CNT_W     = 6;
    localparam int STAT_W    = 3;
    localparam int REQ_W     = 14;

    localparam logic [STAT_W-1:0] STAT_WRITTEN   = 3'd0;
    localparam logic [STAT_W-1:0] STAT_TOO_LONG  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] STAT_DELIVERED = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FINISHED  = 3'd4;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_W_LEN,
        S_W_USED,
        S_W_ROOM,
        S_W_WRAP,
        S_W_PAD,
        S_W_REC,
        S_D_READ,
        S_D_EVAL,
        S_D_FIN
    } t_state;

endpackage

@@ rtl/core/record_ring_space_manager.sv @@
// Top level of the record ring space manager: sequencer, shared adder, positions.
// Depends on rrsm_pkg, rrsm_hdr_mem and record_ring_space_manager_macros.svh.
//
// An item is taken when start is high and busy is low. A write item (action 0)
// asks for room for message_length payload bytes and gives one result with
// o_last set: written with the payload offset, too long, or full. A padding
// record closes the ring end first when the record would run past it.
// A drain item (action 1) walks the headers from the head, reading and then
// evaluating each slot visited, giving one delivered result per message and
// then one finished result with the message count and o_last set. All steps
// share one 32-bit adder and one header memory.
// Results are shown for one cycle with o_result_strobe; the receiver cannot
// stall them. busy drops in the cycle in which the final result is shown.
// After reset the header memory is swept to empty, one slot per cycle, through
// all RING_BYTES / ALIGN_BYTES slots, with busy high. The maximum length register
// may be written with i_cfg_we at any idle time.
`timescale 1ns / 1ps
`include "record_ring_space_manager_macros.svh"

module record_ring_space_manager
    import rrsm_pkg::*;
#(
    parameter int RING_BYTES   = 4096,
    parameter int ALIGN_BYTES  = 8,
    parameter int HEADER_BYTES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_action,
    input  logic [MSG_LEN_W-1:0] i_message_length,
    input  logic [CNT_W-1:0]     i_count_limit,
    input  logic                 i_cfg_we,
    input  logic [MSG_LEN_W-1:0] i_cfg_wdata,
    output logic                 o_result_strobe,
    output logic [STAT_W-1:0]    o_status,
    output logic [OFS_W-1:0]     o_msg_offset,
    output logic [MSG_LEN_W-1:0] o_msg_length,
    output logic [CNT_W-1:0]     o_drained_count,
    output logic                 o_last
);

    localparam int RB     = $clog2(RING_BYTES);
    localparam int AB     = $clog2(ALIGN_BYTES);
    localparam int SLOTS  = RING_BYTES / ALIGN_BYTES;
    localparam int SLOT_W = RB - AB;
    localparam int LEN_W  = RB + 1;
    localparam int ENT_W  = LEN_W + 1;
    localparam int ALN_W  = LEN_W + 1;

    t_state r_state, n_state;

    logic [MSG_LEN_W-1:0] r_max_len;
    logic [31:0]          r_head, n_head;
    logic [31:0]          r_tail, n_tail;
    logic [MSG_LEN_W-1:0] r_length, n_length;
    logic [CNT_W-1:0]     r_limit, n_limit;
    logic [REQ_W-1:0]     r_required, n_required;
    logic [31:0]          r_used, n_used;
    logic                 r_wrap, n_wrap;
    logic [RB:0]          r_cur, n_cur;
    logic [RB-1:0]        r_start, n_start;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [SLOT_W-1:0]    r_clr_idx, n_clr_idx;

    logic                 r_strobe, n_strobe;
    logic [STAT_W-1:0]    r_status, n_status;
    logic [OFS_W-1:0]     r_offset, n_offset;
    logic [MSG_LEN_W-1:0] r_msg_len, n_msg_len;
    logic [CNT_W-1:0]     r_drained, n_drained;
    logic                 r_last, n_last;

    logic [31:0]       alu_a, alu_b;
    logic              alu_cin;
    logic [32:0]       alu_sum;

    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [ENT_W-1:0]  mem_wdata;
    logic [SLOT_W-1:0] mem_raddr;
    logic [ENT_W-1:0]  mem_rdata;

    logic [RB-1:0]     tail_idx, head_idx;
    logic [LEN_W-1:0]  to_end;
    logic [LEN_W-1:0]  rd_len;
    logic              rd_rdy;
    logic [ALN_W-1:0]  rd_aligned;
    logic              too_long, no_room, wraps, no_fit, walk_end, slot_empty;

    assign tail_idx   = r_tail[RB-1:0];
    assign head_idx   = r_head[RB-1:0];
    assign to_end     = LEN_W'(RING_BYTES) - {1'b0, tail_idx};
    assign rd_len     = mem_rdata[LEN_W-1:0];
    assign rd_rdy     = mem_rdata[LEN_W];
    assign rd_aligned = ({1'b0, rd_len} + ALN_W'(ALIGN_BYTES - 1))
                        & ~ALN_W'(ALIGN_BYTES - 1);

    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + 33'(alu_cin);

    assign too_long   = r_length > r_max_len;
    assign no_room    = alu_sum > 33'(RING_BYTES);
    assign wraps      = alu_sum > 33'(RING_BYTES);
    assign no_fit     = 32'(r_required) > 32'(head_idx);
    assign walk_end   = r_cur[RB] || (r_count >= r_limit);
    assign slot_empty = (rd_len == '0);

    assign busy = (r_state != S_IDLE);

    rrsm_hdr_mem #(
        .DEPTH (SLOTS),
        .WIDTH (ENT_W)
    ) u_hdr_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Shared adder operand selection.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_cin = 1'b0;
        unique case (r_state)
            S_W_LEN: begin
                alu_a = 32'(r_length);
                alu_b = 32'(HEADER_BYTES + ALIGN_BYTES - 1);
            end
            S_W_USED: begin
                alu_a   = r_tail;
                alu_b   = ~r_head;
                alu_cin = 1'b1;
            end
            S_W_ROOM: begin
                alu_a = 32'(r_required);
                alu_b = r_used;
            end
            S_W_WRAP: begin
                alu_a = 32'(tail_idx);
                alu_b = 32'(r_required);
            end
            S_W_PAD: begin
                alu_a = r_tail;
                alu_b = 32'(to_end);
            end
            S_W_REC: begin
                alu_a = r_tail;
                alu_b = 32'(r_required);
            end
            S_D_EVAL: begin
                alu_a = 32'(r_cur);
                alu_b = 32'(rd_aligned);
            end
            S_D_FIN: begin
                alu_a = r_head;
                alu_b = 32'((RB + 1)'(r_cur - {1'b0, r_start}));
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == SLOT_W'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = (i_action == ACT_DRAIN) ? S_D_READ : S_W_LEN;
                end
            end
            S_W_LEN:  n_state = too_long ? S_IDLE : S_W_USED;
            S_W_USED: n_state = S_W_ROOM;
            S_W_ROOM: n_state = no_room ? S_IDLE : S_W_WRAP;
            S_W_WRAP: begin
                priority if (wraps && no_fit) begin
                    n_state = S_IDLE;
                end else if (wraps) begin
                    n_state = S_W_PAD;
                end else begin
                    n_state = S_W_REC;
                end
            end
            S_W_PAD:  n_state = S_W_REC;
            S_W_REC:  n_state = S_IDLE;
            S_D_READ: n_state = walk_end ? S_D_FIN : S_D_EVAL;
            S_D_EVAL: n_state = (slot_empty || !rd_rdy) ? S_D_FIN : S_D_READ;
            S_D_FIN:  n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath, memory port and result outputs.
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_length   = r_length;
        n_limit    = r_limit;
        n_required = r_required;
        n_used     = r_used;
        n_wrap     = r_wrap;
        n_cur      = r_cur;
        n_start    = r_start;
        n_count    = r_count;
        n_clr_idx  = r_clr_idx;
        mem_we     = 1'b0;
        mem_waddr  = tail_idx[RB-1:AB];
        mem_wdata  = '0;
        mem_raddr  = r_cur[RB-1:AB];
        n_strobe   = 1'b0;
        n_status   = STAT_WRITTEN;
        n_offset   = '0;
        n_msg_len  = '0;
        n_drained  = '0;
        n_last     = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
                n_clr_idx = r_clr_idx + SLOT_W'(1);
            end
            S_IDLE: begin
                if (start) begin
                    n_length = i_message_length;
                    n_limit  = i_count_limit;
                    n_cur    = {1'b0, head_idx};
                    n_start  = head_idx;
                    n_count  = '0;
                end
            end
            S_W_LEN: begin
                n_required = REQ_W'(alu_sum[31:0] & ~32'(ALIGN_BYTES - 1));
                if (too_long) begin
                    n_strobe = 1'b1;
                    n_status = STAT_TOO_LONG;
                    n_last   = 1'b1;
                end
            end
            S_W_USED: begin
                n_used = alu_sum[31:0];
            end
            S_W_ROOM: begin
                if (no_room) begin
                    n_strobe = 1'b1;
                    n_status = STAT_FULL;
                    n_last   = 1'b1;
                end
            end
            S_W_WRAP: begin
                n_wrap = wraps;
                if (wraps && no_fit) begin
                    n_strobe = 1'b1;
                    n_status = STAT_FULL;
                    n_last   = 1'b1;
                end
            end
            S_W_PAD: begin
                mem_we    = 1'b1;
                mem_wdata = {1'b0, to_end};
                n_tail    = alu_sum[31:0];
            end
            S_W_REC: begin
                mem_we    = 1'b1;
                mem_wdata = {1'b1, LEN_W'(r_length + MSG_LEN_W'(HEADER_BYTES))};
                n_tail    = alu_sum[31:0];
                n_strobe  = 1'b1;
                n_status  = STAT_WRITTEN;
                n_offset  = OFS_W'(RB'(tail_idx + RB'(HEADER_BYTES)));
                n_last    = 1'b1;
            end
            S_D_READ: begin
            end
            S_D_EVAL: begin
                if (!slot_empty) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cur[RB-1:AB];
                    n_cur     = (RB + 1)'(alu_sum);
                    if (rd_rdy) begin
                        n_count  = r_count + CNT_W'(1);
                        n_strobe = 1'b1;
                        n_status = STAT_DELIVERED;
                        n_offset = OFS_W'(RB'(r_cur[RB-1:0] + RB'(HEADER_BYTES)));
                        if (rd_len >= LEN_W'(HEADER_BYTES)) begin
                            n_msg_len = MSG_LEN_W'(rd_len - LEN_W'(HEADER_BYTES));
                        end
                    end
                end
            end
            S_D_FIN: begin
                n_head    = alu_sum[31:0];
                n_strobe  = 1'b1;
                n_status  = STAT_FINISHED;
                n_drained = r_count;
                n_last    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_max_len <= MSG_LEN_W'(512);
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_strobe  <= n_strobe;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_length   <= n_length;
        r_limit    <= n_limit;
        r_required <= n_required;
        r_used     <= n_used;
        r_wrap     <= n_wrap;
        r_cur      <= n_cur;
        r_start    <= n_start;
        r_count    <= n_count;
        r_status   <= n_status;
        r_offset   <= n_offset;
        r_msg_len  <= n_msg_len;
        r_drained  <= n_drained;
        r_last     <= n_last;
    end

    assign o_result_strobe = r_strobe;
    assign o_status        = r_status;
    assign o_msg_offset    = r_offset;
    assign o_msg_length    = r_msg_len;
    assign o_drained_count = r_drained;
    assign o_last          = r_last;

    `RRSM_ASSERT_SAME(a_last_frees, o_result_strobe && o_last, !busy)
    `RRSM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `RRSM_ASSERT_SAME(a_mid_delivered, o_result_strobe && !o_last, o_status == STAT_DELIVERED)
    `RRSM_ASSERT_SAME(a_used_bound, r_state == S_IDLE, (r_tail - r_head) <= 32'(RING_BYTES))
    `RRSM_ASSERT_NEXT(a_pad_only_wrap, r_state == S_W_PAD, r_tail[RB-1:0] == '0 && r_wrap)

endmodule

@@ rtl/core/rrsm_hdr_mem.sv @@
// Header slot memory of the record ring space manager.
// One write port and one read port with registered read data; no dependencies.
`timescale 1ns / 1ps

module rrsm_hdr_mem #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 14
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for record_ring_space_manager: write and drain items are
// checked against fixed expected results or a cycle-free predictor of the ring bookkeeping.
// Depends on rrsm_pkg and the record_ring_space_manager RTL only.
`timescale 1ns / 1ps

module tb;
    import rrsm_pkg::*;

    localparam int RING        = 4096;
    localparam int ALIGN       = 8;
    localparam int HDR         = 8;
    localparam int SLOTS       = RING / ALIGN;
    localparam int SETTLE      = 10;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [OFS_W-1:0]     offset;
        logic [MSG_LEN_W-1:0] length;
        logic [CNT_W-1:0]     count;
        logic                 last;
    } t_result;

    typedef enum logic [1:0] {ROW_WRITE, ROW_DRAIN, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [MSG_LEN_W-1:0] value;
        logic                 typed;
        t_result              want;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_action;
    logic [MSG_LEN_W-1:0] i_message_length;
    logic [CNT_W-1:0]     i_count_limit;
    logic                 i_cfg_we;
    logic [MSG_LEN_W-1:0] i_cfg_wdata;
    logic                 o_result_strobe;
    logic [STAT_W-1:0]    o_status;
    logic [OFS_W-1:0]     o_msg_offset;
    logic [MSG_LEN_W-1:0] o_msg_length;
    logic [CNT_W-1:0]     o_drained_count;
    logic                 o_last;

    record_ring_space_manager u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_message_length(i_message_length),
        .i_count_limit   (i_count_limit),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_result_strobe (o_result_strobe),
        .o_status        (o_status),
        .o_msg_offset    (o_msg_offset),
        .o_msg_length    (o_msg_length),
        .o_drained_count (o_drained_count),
        .o_last          (o_last)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state.
    logic [31:0]          ring_head;
    logic [31:0]          ring_tail;
    logic [13:0]          hdr_len [SLOTS];
    logic                 hdr_ready [SLOTS];
    logic [MSG_LEN_W-1:0] max_len;

    t_result expected_results[$];
    t_result predicted_now[$];

    int errors = 0;
    int cycle_count = 0;
    int idle_pct = 0;
    int n_writes = 0;
    int n_drains = 0;
    int n_results = 0;
    int n_delivered = 0;
    int n_wraps = 0;
    int n_full = 0;
    int n_too_long = 0;
    int n_cfg = 0;

    localparam t_stim_row DIRECTED_ROWS [24] = '{
        '{ROW_DRAIN, 13'd63,   1'b1, '{STAT_FINISHED, 12'd0,  13'd0, 6'd0, 1'b1}},
        '{ROW_WRITE, 13'd0,    1'b1, '{STAT_WRITTEN,  12'd8,  13'd0, 6'd0, 1'b1}},
        '{ROW_WRITE, 13'd513,  1'b1, '{STAT_TOO_LONG, 12'd0,  13'd0, 6'd0, 1'b1}},
        '{ROW_WRITE, 13'd512,  1'b1, '{STAT_WRITTEN,  12'd16, 13'd0, 6'd0, 1'b1}},
        '{ROW_DRAIN, 13'd0,    1'b1, '{STAT_FINISHED, 12'd0,  13'd0, 6'd0, 1'b1}},
        '{ROW_DRAIN, 13'd1,    1'b0, '0},
        '{ROW_DRAIN, 13'd63,   1'b0, '0},
        '{ROW_CFG,   13'd4096, 1'b0, '0},
        '{ROW_WRITE, 13'd4096, 1'b1, '{STAT_FULL,     12'd0,  13'd0, 6'd0, 1'b1}},
        '{ROW_WRITE, 13'd4088, 1'b1, '{STAT_FULL,     12'd0,  13'd0, 6'd0, 1'b1}},
        '{ROW_WRITE, 13'd3000, 1'b0, '0},
        '{ROW_WRITE, 13'd544,  1'b0, '0},
        '{ROW_WRITE, 13'd0,    1'b0, '0},
        '{ROW_DRAIN, 13'd63,   1'b0, '0},
        '{ROW_WRITE, 13'd100,  1'b0, '0},
        '{ROW_DRAIN, 13'd63,   1'b0, '0},
        '{ROW_WRITE, 13'd4000, 1'b1, '{STAT_FULL,     12'd0,  13'd0, 6'd0, 1'b1}},
        '{ROW_WRITE, 13'd3900, 1'b0, '0},
        '{ROW_WRITE, 13'd80,   1'b0, '0},
        '{ROW_DRAIN, 13'd63,   1'b0, '0},
        '{ROW_DRAIN, 13'd63,   1'b0, '0},
        '{ROW_CFG,   13'd0,    1'b0, '0},
        '{ROW_WRITE, 13'd0,    1'b0, '0},
        '{ROW_WRITE, 13'd1,    1'b1, '{STAT_TOO_LONG, 12'd0,  13'd0, 6'd0, 1'b1}}
    };

    function automatic logic [31:0] round_up(logic [31:0] x);
        return (x + 32'(ALIGN - 1)) & ~32'(ALIGN - 1);
    endfunction

    function automatic void note_result(logic [STAT_W-1:0] status, logic [31:0] offset,
                                        logic [31:0] length, logic [31:0] count,
                                        logic last);
        t_result r;
        r.status = status;
        r.offset = OFS_W'(offset & 32'(RING - 1));
        r.length = MSG_LEN_W'(length);
        r.count  = CNT_W'(count);
        r.last   = last;
        predicted_now.push_back(r);
    endfunction

    function automatic void ring_write(logic [MSG_LEN_W-1:0] len);
        logic [31:0] rec;
        logic [31:0] need;
        logic [31:0] used;
        logic [31:0] t_idx;
        logic [31:0] to_end;
        logic [31:0] pad;
        pad = 0;
        if (len > max_len) begin
            n_too_long++;
            note_result(STAT_TOO_LONG, 0, 0, 0, 1'b1);
            return;
        end
        rec    = 32'(len) + 32'(HDR);
        need   = round_up(rec);
        used   = ring_tail - ring_head;
        t_idx  = ring_tail & 32'(RING - 1);
        to_end = 32'(RING) - t_idx;
        if ({1'b0, need} + {1'b0, used} > 33'(RING)
                || (need > to_end && need > (ring_head & 32'(RING - 1)))) begin
            n_full++;
            note_result(STAT_FULL, 0, 0, 0, 1'b1);
            return;
        end
        if (need > to_end) begin
            pad = to_end;
        end
        ring_tail = ring_tail + need + pad;
        if (pad != 0) begin
            hdr_len[t_idx / ALIGN]   = 14'(pad);
            hdr_ready[t_idx / ALIGN] = 1'b0;
            t_idx = 0;
            n_wraps++;
        end
        hdr_len[t_idx / ALIGN]   = 14'(rec);
        hdr_ready[t_idx / ALIGN] = 1'b1;
        note_result(STAT_WRITTEN, t_idx + 32'(HDR), 0, 0, 1'b1);
    endfunction

    function automatic void ring_drain(logic [CNT_W-1:0] limit);
        logic [31:0] h_idx;
        logic [31:0] contig;
        logic [31:0] bytes;
        logic [31:0] cnt;
        logic [31:0] ofs;
        logic [31:0] len;
        int          idx;
        h_idx  = ring_head & 32'(RING - 1);
        contig = 32'(RING) - h_idx;
        bytes  = 0;
        cnt    = 0;
        while (bytes < contig && cnt < 32'(limit)) begin
            ofs = h_idx + bytes;
            idx = int'(ofs / ALIGN);
            len = 32'(hdr_len[idx]);
            if (len == 0) break;
            bytes = bytes + round_up(len);
            if (!hdr_ready[idx]) break;
            cnt++;
            note_result(STAT_DELIVERED, ofs + 32'(HDR),
                        (len >= 32'(HDR)) ? len - 32'(HDR) : 32'd0, 0, 1'b0);
        end
        if (bytes != 0) begin
            for (int s = int'(h_idx / ALIGN); s < SLOTS && s < int'((h_idx + bytes) / ALIGN);
                 s++) begin
                hdr_len[s]   = '0;
                hdr_ready[s] = 1'b0;
            end
            ring_head = ring_head + bytes;
        end
        note_result(STAT_FINISHED, 0, 0, cnt, 1'b1);
    endfunction

    task automatic flag_mismatch(string what);
        errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_result(t_result got, t_result want);
        if (got.status != want.status)
            flag_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.offset != want.offset)
            flag_mismatch($sformatf("offset %0d, expected %0d", got.offset, want.offset));
        if (got.length != want.length)
            flag_mismatch($sformatf("length %0d, expected %0d", got.length, want.length));
        if (got.count != want.count)
            flag_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
        if (got.last != want.last)
            flag_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
    endtask

    // Presents one item, holding it until it is taken, then records what it should produce.
    task automatic present(logic act, logic [MSG_LEN_W-1:0] len, logic [CNT_W-1:0] lim,
                           logic typed, t_result want);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start            <= 1'b1;
        i_action         <= act;
        i_message_length <= len;
        i_count_limit    <= lim;
        do @(posedge i_clk); while (busy);
        predicted_now.delete();
        if (act == ACT_DRAIN) begin
            n_drains++;
            ring_drain(lim);
        end else begin
            n_writes++;
            ring_write(len);
        end
        if (typed) begin
            expected_results.push_back(want);
        end else begin
            foreach (predicted_now[k]) expected_results.push_back(predicted_now[k]);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0 || busy);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_max(logic [MSG_LEN_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        max_len = value;
        n_cfg++;
    endtask

    task automatic random_item();
        logic [MSG_LEN_W-1:0] len;
        logic [CNT_W-1:0]     lim;
        int                   pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            len = MSG_LEN_W'($urandom_range(0, (max_len < 700) ? max_len : 700));
        end else if (pick < 85) begin
            len = MSG_LEN_W'($urandom_range(0, RING));
        end else if (pick < 93) begin
            len = max_len;
        end else begin
            len = (max_len < RING) ? max_len + MSG_LEN_W'(1) : MSG_LEN_W'(RING);
        end
        pick = $urandom_range(99);
        if (pick < 8) begin
            lim = '0;
        end else if (pick < 20) begin
            lim = '1;
        end else if (pick < 60) begin
            lim = CNT_W'($urandom_range(1, 6));
        end else begin
            lim = CNT_W'($urandom_range(0, 63));
        end
        if ($urandom_range(99) < 60) begin
            present(ACT_WRITE, len, lim, 1'b0, '0);
        end else begin
            present(ACT_DRAIN, len, lim, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_result_strobe) begin
            got = '{o_status, o_msg_offset, o_msg_length, o_drained_count, o_last};
            n_results++;
            if (o_status == STAT_DELIVERED) n_delivered++;
            if (expected_results.size() == 0) begin
                flag_mismatch($sformatf("result with status %0d while none expected", o_status));
            end else begin
                check_result(got, expected_results.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("record_ring_space_manager regression: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        start            <= 1'b0;
        i_action         <= ACT_WRITE;
        i_message_length <= '0;
        i_count_limit    <= '0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        ring_head = '0;
        ring_tail = '0;
        max_len   = 13'd512;
        for (int s = 0; s < SLOTS; s++) begin
            hdr_len[s]   = '0;
            hdr_ready[s] = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
                settle();
                write_max(DIRECTED_ROWS[i].value);
            end else begin
                present((DIRECTED_ROWS[i].kind == ROW_DRAIN) ? ACT_DRAIN : ACT_WRITE,
                        DIRECTED_ROWS[i].value, CNT_W'(DIRECTED_ROWS[i].value),
                        DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            settle();
            case (phase)
                0: begin
                    idle_pct = 32;
                    write_max(MSG_LEN_W'(RING));
                end
                1: begin
                    idle_pct = 45;
                    write_max(MSG_LEN_W'($urandom_range(256, RING - 1)));
                end
                default: begin
                    idle_pct = 0;
                    write_max(13'd1024);
                end
            endcase
            repeat (67) random_item();
        end

        start <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
        repeat (2 * SETTLE) @(posedge i_clk);

        $display("Ran %0d writes and %0d drains under %0d length limits; %0d results checked.",
                 n_writes, n_drains, n_cfg, n_results);
        $display("Saw %0d messages delivered, %0d padded wraps, %0d full and %0d too long.",
                 n_delivered, n_wraps, n_full, n_too_long);
        if (errors == 0) begin
            $display("record_ring_space_manager regression: pass");
        end else begin
            $display("record_ring_space_manager regression: fail");
        end
        $finish;
    end

endmodule

@@ record_ring_space_manager.f @@
+incdir+rtl/core
rtl/core/rrsm_pkg.sv
rtl/core/rrsm_hdr_mem.sv
rtl/core/record_ring_space_manager.sv
tb/tb.sv
